>>> design/assert_macros.svh
// Assertion helpers shared by the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, inactive during reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> design/nvr_pkg.sv
`default_nettype none
package nvr_pkg;

  localparam int WORD_W    = 16;
  localparam int T_W       = 18;
  localparam int MAG_W     = 17;
  localparam int SQ_W      = 34;
  localparam int SHIFT_W   = 5;
  localparam int MANT_W    = 18;
  localparam int DIV_STEPS = 35;
  localparam int QUO_W     = 35;
  localparam int DREM_W    = 19;
  localparam int ROOT_STEPS = 18;
  localparam int ROOT_W    = 18;
  localparam int SREM_W    = 20;
  localparam int RAD_W     = 36;
  localparam int PROD_W    = 35;
  localparam int SCL_W     = 51;

  localparam logic [DREM_W-1:0] DIV_REM_INIT = 19'd32768;
  localparam logic [WORD_W-1:0] WORD_MAX     = 16'hFFFF;
  localparam logic [WORD_W-1:0] SIGN_MASK    = 16'h8000;
  localparam logic [MAG_W-1:0]  ONE_MAG      = 17'd65536;

  typedef enum logic {
    REG_FULL_RANGE = 1'b0,
    REG_HAS_ALPHA  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [T_W-1:0] tx;
    logic signed [T_W-1:0] ty;
    logic signed [T_W-1:0] tz;
    logic [WORD_W-1:0]     wx;
    logic [WORD_W-1:0]     wy;
    logic [WORD_W-1:0]     wz;
    logic [WORD_W-1:0]     alpha;
  } carry_t;

  typedef struct packed {
    carry_t              car;
    logic                zero;
    logic [SHIFT_W-1:0]  shift;
    logic [MANT_W-1:0]   mant;
  } mid_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] alpha;
  } res_t;

  typedef struct packed {
    logic last_vld;
    logic adv;
  } back_stat_t;

  // word -> signed Q1.16
  function automatic logic signed [T_W-1:0] decode_word(input logic [WORD_W-1:0] w,
                                                         input logic full);
    logic [MAG_W-1:0] two_w;
    logic [T_W-1:0]   num;
    logic [T_W-1:0]   b;
    logic [T_W:0]     t;
    two_w = {w, 1'b0};
    num   = {1'b0, two_w} + 18'd32767;
    if (full) begin
      b = {1'b0, w ^ SIGN_MASK, 1'b0};
    end else if (num >= 18'd131070) begin
      b = {1'b0, two_w} + 18'd2;
    end else if (num >= 18'd65535) begin
      b = {1'b0, two_w} + 18'd1;
    end else begin
      b = {1'b0, two_w};
    end
    t = {1'b0, b} - 19'd65536;
    return t[T_W-1:0];
  endfunction

  // signed Q1.16 in [-1, 1] -> word
  function automatic logic [WORD_W-1:0] encode_word(input logic signed [T_W-1:0] n,
                                                     input logic full);
    logic [T_W-1:0]  nb;
    logic [SQ_W-1:0] acc;
    logic [MAG_W-1:0] ob;
    logic [T_W-1:0]  hb;
    nb  = n + 18'd65536;
    acc = {nb, 16'd0} - {16'd0, nb} + 34'd65536;
    hb  = nb + 18'd1;
    if (full) begin
      ob = hb[T_W-1:1];
    end else begin
      ob = acc[SQ_W-1:17];
    end
    if (ob > {1'b0, WORD_MAX}) begin
      ob = {1'b0, WORD_MAX};
    end
    if (full) begin
      return ob[WORD_W-1:0] ^ SIGN_MASK;
    end
    return ob[WORD_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [T_W-1:0] t);
    logic [T_W-1:0] neg;
    neg = -t;
    return t[T_W-1] ? neg[MAG_W-1:0] : t[MAG_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/nvr_fifo.sv
`default_nettype none
module nvr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/nvr_front.sv
`default_nettype none
module nvr_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [nvr_pkg::WORD_W-1:0]  x_in,
  input  wire logic [nvr_pkg::WORD_W-1:0]  y_in,
  input  wire logic [nvr_pkg::WORD_W-1:0]  z_in,
  input  wire logic [nvr_pkg::WORD_W-1:0]  alpha_in,
  input  wire logic                        full_range,
  input  wire logic                        has_alpha,
  input  wire logic                        mid_full,
  output logic                             mid_push,
  output nvr_pkg::mid_t                    mid_data
);
  logic adv;
  logic v0, v1, v2, v3, v4;
  nvr_pkg::carry_t c0, c1, c2, c3, c4;
  logic [nvr_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic [nvr_pkg::SQ_W-1:0] sum2;
  logic [nvr_pkg::SQ_W-1:0] m3, m3_next;
  logic [nvr_pkg::SHIFT_W-1:0] s3, s3_next;
  logic [nvr_pkg::SQ_W-1:0] m4, m4_next;
  logic [nvr_pkg::SHIFT_W-1:0] s4, s4_next;
  logic z3, z4;
  logic [nvr_pkg::MAG_W-1:0] ax, ay, az;

  assign adv      = !(v4 && mid_full);
  assign full     = !adv;
  assign mid_push = v4 && adv;

  assign ax = nvr_pkg::mag_of(c0.tx);
  assign ay = nvr_pkg::mag_of(c0.ty);
  assign az = nvr_pkg::mag_of(c0.tz);

  always_comb begin
    m3_next = sum2;
    s3_next = '0;
    if (m3_next[33:2] == '0) begin
      m3_next = m3_next << 32;
      s3_next = 5'd16;
    end
    if (m3_next[33:18] == '0) begin
      m3_next = m3_next << 16;
      s3_next = s3_next + 5'd8;
    end
  end

  always_comb begin
    m4_next = m3;
    s4_next = s3;
    if (m4_next[33:26] == '0) begin
      m4_next = m4_next << 8;
      s4_next = s4_next + 5'd4;
    end
    if (m4_next[33:30] == '0) begin
      m4_next = m4_next << 4;
      s4_next = s4_next + 5'd2;
    end
    if (m4_next[33:32] == '0) begin
      m4_next = m4_next << 2;
      s4_next = s4_next + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= push;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0.tx    <= nvr_pkg::decode_word(x_in, full_range);
      c0.ty    <= nvr_pkg::decode_word(y_in, full_range);
      c0.tz    <= nvr_pkg::decode_word(z_in, full_range);
      c0.wx    <= x_in;
      c0.wy    <= y_in;
      c0.wz    <= z_in;
      c0.alpha <= has_alpha ? alpha_in : '0;
      c1  <= c0;
      sqx <= ax * ax;
      sqy <= ay * ay;
      sqz <= az * az;
      c2   <= c1;
      sum2 <= sqx + sqy + sqz;
      c3 <= c2;
      m3 <= m3_next;
      s3 <= s3_next;
      z3 <= (sum2 == '0);
      c4 <= c3;
      m4 <= m4_next;
      s4 <= s4_next;
      z4 <= z3;
    end
  end

  assign mid_data.car   = c4;
  assign mid_data.zero  = z4;
  assign mid_data.shift = s4;
  assign mid_data.mant  = m4[33:16];
endmodule
`default_nettype wire

>>> design/nvr_back.sv
`default_nettype none
module nvr_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   full_range,
  input  wire logic                   mid_vld,
  input  wire nvr_pkg::mid_t          mid_data,
  output logic                        mid_pop,
  input  wire logic                   out_full,
  output logic                        out_push,
  output nvr_pkg::res_t               out_data,
  output nvr_pkg::back_stat_t         stat
);
  localparam int DN = nvr_pkg::DIV_STEPS;
  localparam int RN = nvr_pkg::ROOT_STEPS;

  logic adv;

  logic                           dv_vld [DN];
  nvr_pkg::mid_t                  dv_ctx [DN];
  logic [nvr_pkg::DREM_W-1:0]     dv_rem [DN];
  logic [nvr_pkg::QUO_W-1:0]      dv_quo [DN];

  logic                           sq_vld  [RN];
  nvr_pkg::mid_t                  sq_ctx  [RN];
  logic [nvr_pkg::RAD_W-1:0]      sq_rest [RN];
  logic [nvr_pkg::SREM_W-1:0]     sq_rem  [RN];
  logic [nvr_pkg::ROOT_W-1:0]     sq_root [RN];

  logic                           mu_vld;
  nvr_pkg::mid_t                  mu_ctx;
  logic [nvr_pkg::PROD_W-1:0]     px, py, pz;

  logic                           sc_vld;
  nvr_pkg::mid_t                  sc_ctx;
  logic signed [nvr_pkg::T_W-1:0] nx, ny, nz;

  logic                           oc_vld;
  nvr_pkg::res_t                  oc_res;

  function automatic logic signed [nvr_pkg::T_W-1:0] scale_lane(
      input logic [nvr_pkg::PROD_W-1:0] p, input logic neg,
      input logic [nvr_pkg::SHIFT_W-1:0] s);
    logic [nvr_pkg::SCL_W-1:0] v;
    logic [nvr_pkg::SQ_W-1:0]  mag;
    logic [nvr_pkg::MAG_W-1:0] lim;
    v   = ({{(nvr_pkg::SCL_W - nvr_pkg::PROD_W){1'b0}}, p} << s) + 51'd65536;
    mag = v[nvr_pkg::SCL_W-1:17];
    lim = (mag > {17'd0, nvr_pkg::ONE_MAG}) ? nvr_pkg::ONE_MAG : mag[nvr_pkg::MAG_W-1:0];
    return neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
  endfunction

  assign adv      = !(oc_vld && out_full);
  assign mid_pop  = adv && mid_vld;
  assign out_push = oc_vld && adv;
  assign out_data = oc_res;
  assign stat.last_vld = oc_vld;
  assign stat.adv      = adv;

  // restoring divide: floor(2^50 / mant), one quotient bit per stage
  for (genvar k = 0; k < DN; k++) begin : g_div
    logic                       vin;
    nvr_pkg::mid_t              cin;
    logic [nvr_pkg::DREM_W-1:0] rin;
    logic [nvr_pkg::QUO_W-1:0]  qin;
    logic [nvr_pkg::DREM_W-1:0] r2;
    logic [nvr_pkg::DREM_W-1:0] dd;
    if (k == 0) begin : g_first
      assign vin = mid_pop;
      assign cin = mid_data;
      assign rin = nvr_pkg::DIV_REM_INIT;
      assign qin = '0;
    end else begin : g_next
      assign vin = dv_vld[k-1];
      assign cin = dv_ctx[k-1];
      assign rin = dv_rem[k-1];
      assign qin = dv_quo[k-1];
    end
    assign r2 = {rin[nvr_pkg::DREM_W-2:0], 1'b0};
    assign dd = {1'b0, cin.mant};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (adv) begin
        dv_vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctx[k] <= cin;
        if (r2 >= dd) begin
          dv_rem[k] <= r2 - dd;
          dv_quo[k] <= {qin[nvr_pkg::QUO_W-2:0], 1'b1};
        end else begin
          dv_rem[k] <= r2;
          dv_quo[k] <= {qin[nvr_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < RN; k++) begin : g_sqrt
    logic                       vin;
    nvr_pkg::mid_t              cin;
    logic [nvr_pkg::RAD_W-1:0]  xin;
    logic [nvr_pkg::SREM_W-1:0] rin;
    logic [nvr_pkg::ROOT_W-1:0] oin;
    logic [nvr_pkg::SREM_W+1:0] r4;
    logic [nvr_pkg::SREM_W+1:0] trial;
    logic [nvr_pkg::SREM_W+1:0] diff;
    if (k == 0) begin : g_first
      assign vin = dv_vld[DN-1];
      assign cin = dv_ctx[DN-1];
      assign xin = {1'b0, dv_quo[DN-1]};
      assign rin = '0;
      assign oin = '0;
    end else begin : g_next
      assign vin = sq_vld[k-1];
      assign cin = sq_ctx[k-1];
      assign xin = sq_rest[k-1];
      assign rin = sq_rem[k-1];
      assign oin = sq_root[k-1];
    end
    assign r4    = {rin, xin[nvr_pkg::RAD_W-1 -: 2]};
    assign trial = {2'b00, oin, 2'b01};
    assign diff  = r4 - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (adv) begin
        sq_vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx[k]  <= cin;
        sq_rest[k] <= xin << 2;
        if (r4 >= trial) begin
          sq_rem[k]  <= diff[nvr_pkg::SREM_W-1:0];
          sq_root[k] <= {oin[nvr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= r4[nvr_pkg::SREM_W-1:0];
          sq_root[k] <= {oin[nvr_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_vld <= 1'b0;
      sc_vld <= 1'b0;
      oc_vld <= 1'b0;
    end else if (adv) begin
      mu_vld <= sq_vld[RN-1];
      sc_vld <= mu_vld;
      oc_vld <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_ctx <= sq_ctx[RN-1];
      px <= nvr_pkg::mag_of(sq_ctx[RN-1].car.tx) * sq_root[RN-1];
      py <= nvr_pkg::mag_of(sq_ctx[RN-1].car.ty) * sq_root[RN-1];
      pz <= nvr_pkg::mag_of(sq_ctx[RN-1].car.tz) * sq_root[RN-1];
      sc_ctx <= mu_ctx;
      nx <= scale_lane(px, mu_ctx.car.tx[nvr_pkg::T_W-1], mu_ctx.shift);
      ny <= scale_lane(py, mu_ctx.car.ty[nvr_pkg::T_W-1], mu_ctx.shift);
      nz <= scale_lane(pz, mu_ctx.car.tz[nvr_pkg::T_W-1], mu_ctx.shift);
      oc_res.alpha <= sc_ctx.car.alpha;
      if (sc_ctx.zero) begin
        oc_res.x <= sc_ctx.car.wx;
        oc_res.y <= sc_ctx.car.wy;
        oc_res.z <= sc_ctx.car.wz;
      end else begin
        oc_res.x <= nvr_pkg::encode_word(nx, full_range);
        oc_res.y <= nvr_pkg::encode_word(ny, full_range);
        oc_res.z <= nvr_pkg::encode_word(nz, full_range);
      end
    end
  end
endmodule
`default_nettype wire

>>> design/normal_vector_renormalize_core.sv
`default_nettype none
// Normal-map pixel renormalizer. Accepts one pixel (x, y, z, alpha words) per
// clock while full is low and returns it scaled to unit length, in the
// encoding selected by full_range (0: unsigned 0..1 words, 1: signed Q1.15).
// A zero-length vector is returned unchanged; alpha is copied or forced to
// zero by has_alpha. Sustained rate is one pixel per clock while the output
// queue is popped. Pipeline length is set by the 35-stage reciprocal divider
// and the 18-stage square root pipeline; the front end (decode, squares,
// normalize shift) is 5 stages. Write registers only while no pixel is in flight.
module normal_vector_renormalize_core #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] x_in,
  input  wire logic [15:0] y_in,
  input  wire logic [15:0] z_in,
  input  wire logic [15:0] alpha_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      x_out,
  output logic [15:0]      y_out,
  output logic [15:0]      z_out,
  output logic [15:0]      alpha_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic full_range;
  logic has_alpha;
  logic cfg_wr;
  nvr_pkg::reg_idx_t cfg_idx;

  logic          mid_push, mid_full, mid_empty, mid_pop;
  nvr_pkg::mid_t mid_in, mid_out;
  logic          out_push, out_full;
  nvr_pkg::res_t res_in, res_out;
  nvr_pkg::back_stat_t back_stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = nvr_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      full_range <= 1'b0;
      has_alpha  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nvr_pkg::REG_FULL_RANGE: full_range <= pwdata[0];
        nvr_pkg::REG_HAS_ALPHA:  has_alpha  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nvr_pkg::REG_FULL_RANGE: prdata = {31'd0, full_range};
      nvr_pkg::REG_HAS_ALPHA:  prdata = {31'd0, has_alpha};
      default:                 prdata = '0;
    endcase
  end

  nvr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .alpha_in(alpha_in),
    .full_range(full_range), .has_alpha(has_alpha),
    .mid_full(mid_full), .mid_push(mid_push), .mid_data(mid_in)
  );

  nvr_fifo #(.W($bits(nvr_pkg::mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .push(mid_push), .din(mid_in), .full(mid_full),
    .pop(mid_pop), .dout(mid_out), .empty(mid_empty)
  );

  nvr_back u_back (
    .clk(clk), .rst(rst), .full_range(full_range),
    .mid_vld(!mid_empty), .mid_data(mid_out), .mid_pop(mid_pop),
    .out_full(out_full), .out_push(out_push), .out_data(res_in), .stat(back_stat)
  );

  nvr_fifo #(.W($bits(nvr_pkg::res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .push(out_push), .din(res_in), .full(out_full),
    .pop(pop), .dout(res_out), .empty(empty)
  );

  assign x_out     = res_out.x;
  assign y_out     = res_out.y;
  assign z_out     = res_out.z;
  assign alpha_out = res_out.alpha;

`include "assert_macros.svh"

  `ASSERT_IMP(a_mid_no_overflow, mid_push, !mid_full)
  `ASSERT_NXT(a_back_holds, back_stat.last_vld && out_full, back_stat.last_vld)
  `ASSERT_IMP(a_back_push_room, out_push, !out_full && back_stat.adv)
  `ASSERT_RST(a_reset_empty, rst, empty)
endmodule
`default_nettype wire
